// ===== hw/rtl/best_fit_bin_packer_assert.svh =====
// Assertion macros for the best-fit bin packer.
`ifndef BEST_FIT_BIN_PACKER_ASSERT_SVH
`define BEST_FIT_BIN_PACKER_ASSERT_SVH
`ifndef ASSERT_OFF
// label: antecedent implies consequent in the same cycle
`define BFBP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfbp assertion failed");
// label: antecedent implies consequent in the next cycle
`define BFBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfbp assertion failed");
`else
`define BFBP_ASSERT_NOW(label, clk, rst, ante, cons)
`define BFBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/bfbp_pkg.sv =====
// Shared types and constants for the best-fit bin packer.
package bfbp_pkg;

  localparam int NUM_BINS_DEF = 16;
  localparam int VOL_W        = 8;
  localparam int BIN_IDX_W    = 4;
  localparam int COUNT_W      = 5;

  localparam logic [VOL_W-1:0]   CAP_RESET = 8'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } bfbp_state_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic start;   // drop the running best
    logic sample;  // a bin's free space is on the compare inputs
  } bfbp_scan_ctl_t;

endpackage

// ===== hw/rtl/bfbp_best_fit.sv =====
// Shared compare unit: tracks the tightest fitting bin over a scan.
module bfbp_best_fit #(
  parameter int IDX_W = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bfbp_pkg::bfbp_scan_ctl_t    ctl,
  input  logic [bfbp_pkg::VOL_W-1:0]  volume,
  input  logic [bfbp_pkg::VOL_W-1:0]  space,
  input  logic [IDX_W-1:0]            idx,
  output logic                        found,
  output logic [IDX_W-1:0]            best_idx,
  output logic [bfbp_pkg::VOL_W-1:0]  best_space
);
  import bfbp_pkg::*;

  logic fits;

  // strict less-than keeps the lowest index on ties
  assign fits = (volume <= space) && (!found || (space < best_space));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (ctl.sample && fits) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample && fits) begin
      best_idx   <= idx;
      best_space <= space;
    end
  end

endmodule

// ===== hw/rtl/best_fit_bin_packer.sv =====
// Online best-fit bin packer: sequencer, bin store and result register.
//
// Channels: cfg (cfg_valid/cfg_ready/cfg_data) writes the bin capacity; it is
// always ready and the new capacity reaches the bins at the next clear.
// in (in_valid/in_ready, command, volume) takes one beat per command;
// out (out_valid/out_ready, placed, bin_index, space_left, bins_used) gives
// exactly one beat per command.
// A place command scans every bin through one compare unit: one memory read
// per cycle, then a write step that writes the chosen bin and loads the result.
// A clear goes from idle straight to the write step. The scan is bound by the
// single read port of the free-space memory and the one compare; a command is
// taken only from idle, so the next one waits until the last one has loaded
// its result.
// in_ready is high only while the sequencer is idle.
// The result register is separate from the sequencer: a new command is taken
// while a result waits; if the receiver still stalls when the next result is
// ready, the sequencer holds in its write step until the register frees up.
// Reset: capacity 100, all bins empty and unused, no pending result. Bins
// come up empty through per-bin used bits, so no clearing sweep is needed.
`include "best_fit_bin_packer_assert.svh"

module best_fit_bin_packer #(
  parameter int NUM_BINS = bfbp_pkg::NUM_BINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfbp_pkg::VOL_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [bfbp_pkg::VOL_W-1:0]      volume,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            placed,
  output logic [bfbp_pkg::BIN_IDX_W-1:0]  bin_index,
  output logic [bfbp_pkg::VOL_W-1:0]      space_left,
  output logic [bfbp_pkg::COUNT_W-1:0]    bins_used
);
  import bfbp_pkg::*;

  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NUM_BINS + 1);

  // sequencer
  bfbp_state_t    state, state_next;
  bfbp_scan_ctl_t scan_ctl;
  logic           in_beat;
  logic           rd_en;
  logic           load_out;
  logic           slot_free;
  logic [CNT_W-1:0] cnt;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;

  // latched command
  logic             cmd;
  logic [VOL_W-1:0] vol;

  // capacity register and the capacity bins take at clear
  logic [VOL_W-1:0] bin_capacity;
  logic [VOL_W-1:0] clear_cap;

  // bin store: unused bins read as clear_cap
  logic [VOL_W-1:0]    mem [NUM_BINS];
  logic [NUM_BINS-1:0] bin_used;
  logic [VOL_W-1:0]    rd_data;
  logic                rd_used;
  logic [VOL_W-1:0]    rd_space;
  logic [COUNT_W-1:0]  used_count, used_count_next;

  // compare unit
  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic [VOL_W-1:0] best_space;
  logic [VOL_W-1:0] left;
  logic             place_ok;

  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    scan_ctl   = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          scan_ctl.start = 1'b1;
          state_next = (command == CMD_CLEAR) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en           = (cnt != CNT_W'(NUM_BINS));
        scan_ctl.sample = rd_pend;
        if (!rd_en && !rd_pend) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // read address counter and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (in_beat) begin
        cnt <= '0;
      end else if (rd_en) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (in_beat) begin
      cmd <= command;
      vol <= volume;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bin_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cap <= CAP_RESET;
    end else if (in_beat && command == CMD_CLEAR) begin
      clear_cap <= bin_capacity;
    end
  end

  // free-space memory: one read port for the scan, one write for the update
  always_ff @(posedge clk) begin
    if (place_ok) begin
      mem[best_idx] <= left;
    end
    if (rd_en) begin
      rd_data <= mem[cnt[IDX_W-1:0]];
      rd_used <= bin_used[cnt[IDX_W-1:0]];
    end
  end

  assign rd_space = rd_used ? rd_data : clear_cap;

  bfbp_best_fit #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .volume     (vol),
    .space      (rd_space),
    .idx        (rd_idx),
    .found      (found),
    .best_idx   (best_idx),
    .best_space (best_space)
  );

  assign left     = best_space - vol;
  assign place_ok = load_out && (cmd == CMD_PLACE) && found;

  // count saturates; a bin already in use does not count twice
  always_comb begin
    used_count_next = used_count;
    if (place_ok && !bin_used[best_idx] && (used_count != COUNT_MAX)) begin
      used_count_next = used_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_used   <= '0;
      used_count <= '0;
    end else if (in_beat && command == CMD_CLEAR) begin
      bin_used   <= '0;
      used_count <= '0;
    end else begin
      used_count <= used_count_next;
      if (place_ok) begin
        bin_used[best_idx] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      placed     <= place_ok;
      bin_index  <= place_ok ? BIN_IDX_W'(best_idx) : '0;
      space_left <= place_ok ? left : '0;
      bins_used  <= used_count_next;
    end
  end

  // no memory read in flight once the sequencer is back to idle
  `BFBP_ASSERT_NOW(a_idle_no_read, clk, rst, state == ST_IDLE, !rd_pend && !rd_en)
  // the used count tracks the used bits, saturating
  `BFBP_ASSERT_NOW(a_count_match, clk, rst, 1'b1,
    ($countones(bin_used) >= 31) ? (used_count == COUNT_MAX) :
                                   (int'(used_count) == $countones(bin_used)))
  // a result load always returns the sequencer to idle with a beat pending
  `BFBP_ASSERT_NEXT(a_load_done, clk, rst, load_out, out_valid && state == ST_IDLE)

endmodule

// ===== dv/tb_best_fit_bin_packer.sv =====
// Self-checking testbench for the best-fit bin packer: directed script, then random phases.
`timescale 1ns / 1ps

module tb_best_fit_bin_packer;
  import bfbp_pkg::*;

  // Run length guard. The slowest legal run is about 2000 commands, each with
  // the longest sender gap, a full scan and the longest result stall; this
  // limit still leaves ample margin.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SHOW_MAX     = 10;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 160;
  localparam int SETTLE_TICKS = 40;

  typedef struct packed {
    logic                 placed;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [VOL_W-1:0]     space_left;
    logic [COUNT_W-1:0]   bins_used;
  } pack_result_t;

  typedef enum logic {ROW_COMMAND, ROW_CAPACITY} row_kind_t;

  // One line of the directed script. For capacity rows, vol holds the new capacity.
  typedef struct {
    row_kind_t    kind;
    logic         cmd;
    logic [VOL_W-1:0] vol;
    bit           typed;      // want holds a hand-written result
    pack_result_t want;
  } script_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [VOL_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic             command;
  logic [VOL_W-1:0] volume;
  logic             out_valid;
  logic             out_ready;
  logic             placed;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [VOL_W-1:0]     space_left;
  logic [COUNT_W-1:0]   bins_used;

  best_fit_bin_packer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .volume     (volume),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .placed     (placed),
    .bin_index  (bin_index),
    .space_left (space_left),
    .bins_used  (bins_used)
  );

  // Shadow copy of the packer state, advanced once per accepted input beat.
  logic [VOL_W-1:0]   bin_space [NUM_BINS_DEF];
  logic               bin_taken [NUM_BINS_DEF];
  logic [COUNT_W-1:0] taken_count;
  logic [VOL_W-1:0]   capacity;

  pack_result_t pending_results[$];   // results owed by the DUT, oldest first
  script_row_t  script[$];

  int  error_count;
  int  shown_count;
  int  cycle_count;
  int  commands_sent;
  int  fits_seen;
  int  misses_seen;
  int  clears_seen;
  int  capacity_writes;
  bit  steady_flow;       // phase with no idling on either side

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Fill every bin to the current capacity and drop all used marks.
  function automatic void refill_bins();
    for (int b = 0; b < NUM_BINS_DEF; b++) begin
      bin_space[b] = capacity;
      bin_taken[b] = 1'b0;
    end
    taken_count = '0;
  endfunction

  // Best fit: among bins with room, the one with least free space; the strict
  // compare keeps the lowest index on ties. A miss leaves the state alone.
  function automatic pack_result_t predict_packing(logic cmd, logic [VOL_W-1:0] vol);
    pack_result_t r;
    bit hit;
    int best;
    r = '0;
    hit = 1'b0;
    best = 0;
    if (cmd == CMD_CLEAR) begin
      refill_bins();
      return r;
    end
    for (int b = 0; b < NUM_BINS_DEF; b++) begin
      if (vol <= bin_space[b] && (!hit || bin_space[b] < bin_space[best])) begin
        hit = 1'b1;
        best = b;
      end
    end
    if (hit) begin
      bin_space[best] = bin_space[best] - vol;
      if (!bin_taken[best]) begin
        bin_taken[best] = 1'b1;
        if (taken_count != COUNT_MAX) taken_count = taken_count + 1'b1;
      end
      r.placed     = 1'b1;
      r.bin_index  = best[BIN_IDX_W-1:0];
      r.space_left = bin_space[best];
    end
    r.bins_used = taken_count;
    return r;
  endfunction

  // Idle lengths: mostly short, now and then long enough to span a whole scan.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_row(row_kind_t kind, logic cmd, logic [VOL_W-1:0] vol,
                                  bit typed, logic p, logic [BIN_IDX_W-1:0] b,
                                  logic [VOL_W-1:0] s, logic [COUNT_W-1:0] u);
    script_row_t row;
    row.kind  = kind;
    row.cmd   = cmd;
    row.vol   = vol;
    row.typed = typed;
    row.want  = '{placed: p, bin_index: b, space_left: s, bins_used: u};
    script = {script, row};
  endfunction

  // Present one command beat, hold it until taken, then log what it should produce.
  // Inputs move only at the falling edge; acceptance is judged at the rising edge.
  task automatic send_command(logic cmd, logic [VOL_W-1:0] vol, bit typed,
                              pack_result_t typed_result);
    int gap;
    pack_result_t want;
    gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    volume   <= vol;
    do @(posedge clk); while (!in_ready);
    want = predict_packing(cmd, vol);
    pending_results = {pending_results, (typed ? typed_result : want)};
    commands_sent++;
    if (cmd == CMD_CLEAR) clears_seen++;
    else if (want.placed) fits_seen++;
    else misses_seen++;
  endtask

  // Stop sending and wait for every owed result beat to come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Capacity writes only happen with the block idle.
  task automatic write_capacity(logic [VOL_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    capacity = value;
    capacity_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random backpressure on the result channel, none in steady phases.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Result checker: every result beat must match the oldest pending result.
  always @(posedge clk) begin
    pack_result_t got;
    pack_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{placed: placed, bin_index: bin_index, space_left: space_left,
              bins_used: bins_used};
      if (pending_results.size() == 0) begin
        error_count++;
        if (shown_count < SHOW_MAX) begin
          shown_count++;
          $display("[%0t] unexpected result beat: placed=%0d bin=%0d left=%0d used=%0d",
                   $realtime, got.placed, got.bin_index, got.space_left, got.bins_used);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (shown_count < SHOW_MAX) begin
            shown_count++;
            $display("[%0t] mismatch: want placed=%0d bin=%0d left=%0d used=%0d",
                     $realtime, want.placed, want.bin_index, want.space_left,
                     want.bins_used);
            $display("[%0t]           got  placed=%0d bin=%0d left=%0d used=%0d",
                     $realtime, got.placed, got.bin_index, got.space_left,
                     got.bins_used);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("** best_fit_bin_packer: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VOL_W-1:0] vol;
    logic             cmd;
    int               pick;
    int               cap_hi;
    pack_result_t     none;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = CMD_PLACE;
    volume    = '0;
    none      = '0;
    steady_flow     = 1'b0;
    error_count     = 0;
    shown_count     = 0;
    cycle_count     = 0;
    commands_sent   = 0;
    fits_seen       = 0;
    misses_seen     = 0;
    clears_seen     = 0;
    capacity_writes = 0;
    capacity = CAP_RESET;
    refill_bins();

    // Directed script. Typed rows are simple enough to read off by hand;
    // the rest lean on the shadow model.
    // Reset state, capacity 100: exact fill, oversize miss, zero volume.
    add_row(ROW_COMMAND, CMD_PLACE, 8'd100, 1'b1, 1'b1, 4'd0, 8'd0,  5'd1);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd255, 1'b1, 1'b0, 4'd0, 8'd0,  5'd1);
    // zero volume fits the full bin 0 and best fit picks it
    add_row(ROW_COMMAND, CMD_PLACE, 8'd0,   1'b1, 1'b1, 4'd0, 8'd0,  5'd1);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd1,   1'b1, 1'b1, 4'd1, 8'd99, 5'd2);
    // best fit versus first fit, tighter bin wins
    add_row(ROW_COMMAND, CMD_PLACE, 8'd99,  1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd50,  1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd60,  1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd40,  1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd30,  1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd101, 1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    // new capacity must not touch filled bins until a clear
    add_row(ROW_CAPACITY, CMD_PLACE, 8'd255, 1'b0, 1'b0, 4'd0, 8'd0, 5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd200, 1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_CLEAR, 8'd0,   1'b1, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd255, 1'b1, 1'b1, 4'd0, 8'd0,  5'd1);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd128, 1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd127, 1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    // clear ignores its volume
    add_row(ROW_COMMAND, CMD_CLEAR, 8'd255, 1'b1, 1'b0, 4'd0, 8'd0,  5'd0);
    // zero capacity: nothing of size 1 fits, zero volume still does
    add_row(ROW_CAPACITY, CMD_PLACE, 8'd0,  1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_CLEAR, 8'd0,   1'b1, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd1,   1'b1, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd0,   1'b1, 1'b1, 4'd0, 8'd0,  5'd1);
    // smallest nonzero capacity
    add_row(ROW_CAPACITY, CMD_PLACE, 8'd1,  1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_CLEAR, 8'd0,   1'b1, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd1,   1'b1, 1'b1, 4'd0, 8'd0,  5'd1);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd1,   1'b0, 1'b0, 4'd0, 8'd0,  5'd0);
    add_row(ROW_COMMAND, CMD_PLACE, 8'd0,   1'b0, 1'b0, 4'd0, 8'd0,  5'd0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CAPACITY) write_capacity(script[i].vol);
      else send_command(script[i].cmd, script[i].vol, script[i].typed, script[i].want);
    end

    // Random phases: each starts idle with a new capacity (extremes first),
    // usually followed by a clear so the new capacity takes hold.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) write_capacity(8'd255);
      else if (phase == 1) write_capacity(8'd1);
      else write_capacity(VOL_W'($urandom_range(1, 255)));
      steady_flow = (phase % 4 == 3);
      if ($urandom_range(0, 3) != 0) begin
        send_command(CMD_CLEAR, VOL_W'($urandom_range(0, 255)), 1'b0, none);
      end
      cap_hi = (capacity == 0) ? 1 : capacity;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        cmd  = CMD_PLACE;
        if (pick < 3) begin
          cmd = CMD_CLEAR;
          vol = VOL_W'($urandom_range(0, 255));
        end else if (pick < 8) begin
          vol = VOL_W'($urandom_range(0, 255));
        end else if (pick < 10) begin
          vol = '0;
        end else if (pick < 50) begin
          vol = VOL_W'($urandom_range(1, (cap_hi / 4 > 1) ? cap_hi / 4 : 1));
        end else begin
          vol = VOL_W'($urandom_range(1, cap_hi));
        end
        send_command(cmd, vol, 1'b0, none);
        // occasionally let everything in flight drain mid-phase
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    steady_flow = 1'b0;
    // extra cycles to catch stray result beats
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("Ran %0d commands under %0d capacity settings: %0d placed, %0d misses, %0d clears.",
             commands_sent, capacity_writes, fits_seen, misses_seen, clears_seen);
    $display("Result beats checked with random stalls on both channels; %0d errors.",
             error_count);
    if (error_count == 0) begin
      $display("** best_fit_bin_packer: PASSED **");
    end else begin
      $display("** best_fit_bin_packer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bfbp_pkg.sv
hw/rtl/bfbp_best_fit.sv
hw/rtl/best_fit_bin_packer.sv
dv/tb_best_fit_bin_packer.sv
